// ===== src/hsv2rgb_pkg.sv =====
// Shared types, constants and helpers for the HSV to RGB converter.
// Used by hsv2rgb_generic, hsv2rgb_rainbow and hsv_to_rgb_converter.
package hsv2rgb_pkg;

   // Register stages inside each conversion datapath; the output register comes after them.
   localparam int PIPE_STAGES = 4;

   localparam logic [7:0] CHAN_MAX    = 8'd255;
   localparam logic [7:0] REGION_SPAN = 8'd43;
   localparam logic [7:0] GREEN_SCALE = 8'd185;
   localparam logic [7:0] ONE_THIRD   = 8'(256 / 3);
   localparam logic [7:0] TWO_THIRDS  = 8'((256 * 2) / 3);

   // Algorithm codes held in the configuration register.
   localparam logic ALGO_GENERIC = 1'b0;
   localparam logic ALGO_RAINBOW = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef logic [PIPE_STAGES-1:0] stage_en_type;

   // Upper byte of an 8 by 8 product.
   function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = 16'(a) * 16'(b);
      return prod[15:8];
   endfunction

endpackage

// ===== src/hsv_to_rgb_converter.sv =====
// HSV to RGB converter top level: flow control, algorithm register and output register.
// Depends on hsv2rgb_pkg, hsv2rgb_generic and hsv2rgb_rainbow.
//
// Usage: one hue, saturation, value word enters on the req_ stream and one red, green,
// blue word leaves on the rsp_ stream, in the same order. csr_wr_en writes bit 0 of
// csr_wr_data into the algorithm register (0 six-region, 1 rainbow); write it only
// while no word is in flight. Each word carries the algorithm that was set when it
// was accepted.
// From acceptance a word passes the four datapath stages and then the output register
// before rsp_tvalid. Throughput is one word per clock while rsp_tready stays high; both
// datapaths are fully pipelined and every stage has its own valid bit.
// When the receiver holds rsp_tready low, the output word is held and stages upstream
// keep filling any empty slots; req_tready drops only when all five stages hold words.
// A synchronous reset empties the pipeline and selects the six-region algorithm.
module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // hue [7:0], saturation [15:8], value [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                   algo_ff;
   logic [PIPE_STAGES:0]   vld_ff, vld_in;
   logic [PIPE_STAGES:0]   en;
   logic [PIPE_STAGES-1:0] mode_ff, mode_in;
   rgb_type                gen_rgb, rb_rgb;
   rgb_type                rsp_ff, rsp_in;

   // A stage loads when it is empty or the stage after it loads too.
   always_comb begin
      en[PIPE_STAGES] = !vld_ff[PIPE_STAGES] || rsp_tready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in  = {vld_ff[PIPE_STAGES-1:0], req_tvalid};
   assign mode_in = {mode_ff[PIPE_STAGES-2:0], algo_ff};
   assign rsp_in  = (mode_ff[PIPE_STAGES-1] == ALGO_RAINBOW) ? rb_rgb : gen_rgb;

   always_ff @(posedge clock) begin
      if (reset) begin
         algo_ff <= ALGO_GENERIC;
         vld_ff  <= '0;
      end else begin
         if (csr_wr_en) algo_ff <= csr_wr_data;
         for (int k = 0; k <= PIPE_STAGES; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         if (en[k]) mode_ff[k] <= mode_in[k];
      end
      if (en[PIPE_STAGES]) rsp_ff <= rsp_in;
   end

   hsv2rgb_generic u_generic (
      .clock      (clock),
      .stage_en   (en[PIPE_STAGES-1:0]),
      .hue        (req_tdata[7:0]),
      .saturation (req_tdata[15:8]),
      .value      (req_tdata[23:16]),
      .rgb        (gen_rgb)
   );

   hsv2rgb_rainbow u_rainbow (
      .clock      (clock),
      .stage_en   (en[PIPE_STAGES-1:0]),
      .hue        (req_tdata[7:0]),
      .saturation (req_tdata[15:8]),
      .value      (req_tdata[23:16]),
      .rgb        (rb_rgb)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[PIPE_STAGES];
   assign rsp_tdata  = {rsp_ff.blue, rsp_ff.green, rsp_ff.red};

   // The input side only stalls when every stage holds a word.
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> &vld_ff)
      else $error("input stalled while a pipeline slot was free");

   // An accepted word always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted word lost at pipeline entry");

   // A word leaving the last datapath stage must reach the output register.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_STAGES-1] && en[PIPE_STAGES] |=> rsp_tvalid)
      else $error("word lost between datapath and output register");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

// ===== src/hsv2rgb_generic.sv =====
// Six-region integer HSV to RGB datapath, four register stages.
// Depends on hsv2rgb_pkg; stage enables come from the top-level flow control.
module hsv2rgb_generic
   import hsv2rgb_pkg::*;
(
   input  logic         clock,
   input  stage_en_type stage_en,
   input  logic [7:0]   hue,
   input  logic [7:0]   saturation,
   input  logic [7:0]   value,
   output rgb_type      rgb
);

   typedef struct packed {
      logic [7:0] sat;
      logic [7:0] val;
      logic [2:0] region;
      logic [7:0] rem;
      logic [7:0] p;
   } s1_type;

   typedef struct packed {
      logic       sat_zero;
      logic [7:0] val;
      logic [2:0] region;
      logic [7:0] p;
      logic [7:0] sr;
      logic [7:0] st;
   } s2_type;

   typedef struct packed {
      logic       sat_zero;
      logic [7:0] val;
      logic [2:0] region;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } s3_type;

   localparam logic [2:0] REGION_0 = 3'd0;
   localparam logic [2:0] REGION_1 = 3'd1;
   localparam logic [2:0] REGION_2 = 3'd2;
   localparam logic [2:0] REGION_3 = 3'd3;
   localparam logic [2:0] REGION_4 = 3'd4;
   localparam logic [2:0] REGION_5 = 3'd5;

   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   s3_type  s3_in, s3_ff;
   rgb_type rgb_in, rgb_ff;
   logic [7:0] base;
   logic [7:0] offset;

   // The hue is split into regions of 43 steps by comparing against the region edges.
   always_comb begin
      if (hue >= 8'(5 * REGION_SPAN)) begin
         s1_in.region = REGION_5;
         base = 8'(5 * REGION_SPAN);
      end else if (hue >= 8'(4 * REGION_SPAN)) begin
         s1_in.region = REGION_4;
         base = 8'(4 * REGION_SPAN);
      end else if (hue >= 8'(3 * REGION_SPAN)) begin
         s1_in.region = REGION_3;
         base = 8'(3 * REGION_SPAN);
      end else if (hue >= 8'(2 * REGION_SPAN)) begin
         s1_in.region = REGION_2;
         base = 8'(2 * REGION_SPAN);
      end else if (hue >= REGION_SPAN) begin
         s1_in.region = REGION_1;
         base = REGION_SPAN;
      end else begin
         s1_in.region = REGION_0;
         base = 8'd0;
      end
      offset    = hue - base;
      // The offset stays below 43, so six times it fits in a byte.
      s1_in.rem = (offset << 2) + (offset << 1);
      s1_in.sat = saturation;
      s1_in.val = value;
      s1_in.p   = scale8(value, CHAN_MAX - saturation);
   end

   always_comb begin
      s2_in.sat_zero = (s1_ff.sat == 8'd0);
      s2_in.val      = s1_ff.val;
      s2_in.region   = s1_ff.region;
      s2_in.p        = s1_ff.p;
      s2_in.sr       = scale8(s1_ff.sat, s1_ff.rem);
      s2_in.st       = scale8(s1_ff.sat, CHAN_MAX - s1_ff.rem);
   end

   always_comb begin
      s3_in.sat_zero = s2_ff.sat_zero;
      s3_in.val      = s2_ff.val;
      s3_in.region   = s2_ff.region;
      s3_in.p        = s2_ff.p;
      s3_in.q        = scale8(s2_ff.val, CHAN_MAX - s2_ff.sr);
      s3_in.t        = scale8(s2_ff.val, CHAN_MAX - s2_ff.st);
   end

   always_comb begin
      if (s3_ff.sat_zero) begin
         rgb_in = '{red: s3_ff.val, green: s3_ff.val, blue: s3_ff.val};
      end else begin
         unique case (s3_ff.region)
            REGION_0: rgb_in = '{red: s3_ff.val, green: s3_ff.t,   blue: s3_ff.p};
            REGION_1: rgb_in = '{red: s3_ff.q,   green: s3_ff.val, blue: s3_ff.p};
            REGION_2: rgb_in = '{red: s3_ff.p,   green: s3_ff.val, blue: s3_ff.t};
            REGION_3: rgb_in = '{red: s3_ff.p,   green: s3_ff.q,   blue: s3_ff.val};
            REGION_4: rgb_in = '{red: s3_ff.t,   green: s3_ff.p,   blue: s3_ff.val};
            default:  rgb_in = '{red: s3_ff.val, green: s3_ff.p,   blue: s3_ff.q};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_ff  <= s1_in;
      if (stage_en[1]) s2_ff  <= s2_in;
      if (stage_en[2]) s3_ff  <= s3_in;
      if (stage_en[3]) rgb_ff <= rgb_in;
   end

   assign rgb = rgb_ff;

endmodule

// ===== src/hsv2rgb_rainbow.sv =====
// Eight-section rainbow HSV to RGB datapath: four register stages, then the
// value dimming step feeding the top-level output register. Depends on hsv2rgb_pkg.
module hsv2rgb_rainbow
   import hsv2rgb_pkg::*;
(
   input  logic         clock,
   input  stage_en_type stage_en,
   input  logic [7:0]   hue,
   input  logic [7:0]   saturation,
   input  logic [7:0]   value,
   output rgb_type      rgb
);

   localparam logic [7:0] BASE_LO  = 8'd85;
   localparam logic [7:0] BASE_MID = 8'd170;
   localparam logic [7:0] BASE_HI  = 8'd171;

   localparam logic [2:0] SEC_0 = 3'd0;
   localparam logic [2:0] SEC_1 = 3'd1;
   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;
   localparam logic [2:0] SEC_5 = 3'd5;
   localparam logic [2:0] SEC_6 = 3'd6;

   typedef struct packed {
      logic [2:0] sec;
      logic [7:0] th;
      logic [7:0] tt;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] fl;
      logic [7:0] v2;
   } s1_type;

   typedef struct packed {
      rgb_type    col;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] fl;
      logic [7:0] v2;
   } s2_type;

   typedef struct packed {
      rgb_type    col;
      logic [7:0] val;
      logic [7:0] v2;
   } s4_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s2_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   logic [7:0] frac8;

   // Nonzero channels are scaled; every channel is then lifted by the desaturation floor.
   function automatic logic [7:0] sat_adj(input logic [7:0] c, input logic [7:0] s,
                                          input logic [7:0] fl);
      logic [7:0] scaled;
      scaled = (c != 8'd0) ? scale8(c, s) + 8'd1 : 8'd0;
      return scaled + fl;
   endfunction

   function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] v2);
      logic [7:0] res;
      if (v2 == 8'd0) res = 8'd0;
      else if (c != 8'd0) res = scale8(c, v2) + 8'd1;
      else res = 8'd0;
      return res;
   endfunction

   always_comb begin
      frac8     = {hue[4:0], 3'b000};
      s1_in.sec = hue[7:5];
      s1_in.th  = scale8(frac8, ONE_THIRD);
      s1_in.tt  = scale8(frac8, TWO_THIRDS);
      s1_in.sat = saturation;
      s1_in.val = value;
      s1_in.fl  = scale8(CHAN_MAX - saturation, CHAN_MAX - saturation);
      s1_in.v2  = scale8(value, value);
   end

   always_comb begin
      s2_in.sat = s1_ff.sat;
      s2_in.val = s1_ff.val;
      s2_in.fl  = s1_ff.fl;
      s2_in.v2  = s1_ff.v2;
      unique case (s1_ff.sec)
         SEC_0: s2_in.col = '{red: CHAN_MAX - s1_ff.th, green: s1_ff.th, blue: 8'd0};
         SEC_1: s2_in.col = '{red: BASE_HI, green: BASE_LO + s1_ff.th, blue: 8'd0};
         SEC_2: s2_in.col = '{red: BASE_HI - s1_ff.tt, green: BASE_MID + s1_ff.th,
                              blue: 8'd0};
         SEC_3: s2_in.col = '{red: 8'd0, green: CHAN_MAX - s1_ff.th, blue: s1_ff.th};
         SEC_4: s2_in.col = '{red: 8'd0, green: BASE_HI - s1_ff.tt,
                              blue: BASE_LO + s1_ff.tt};
         SEC_5: s2_in.col = '{red: s1_ff.th, green: 8'd0, blue: CHAN_MAX - s1_ff.th};
         SEC_6: s2_in.col = '{red: BASE_LO + s1_ff.th, green: 8'd0,
                              blue: BASE_HI - s1_ff.th};
         default: s2_in.col = '{red: BASE_MID + s1_ff.th, green: 8'd0,
                                blue: BASE_LO - s1_ff.th};
      endcase
   end

   always_comb begin
      s3_in           = s2_ff;
      s3_in.col.green = scale8(s2_ff.col.green, GREEN_SCALE);
   end

   always_comb begin
      s4_in.val = s3_ff.val;
      s4_in.v2  = s3_ff.v2;
      if (s3_ff.sat == CHAN_MAX) begin
         s4_in.col = s3_ff.col;
      end else if (s3_ff.sat == 8'd0) begin
         s4_in.col = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};
      end else begin
         s4_in.col.red   = sat_adj(s3_ff.col.red,   s3_ff.sat, s3_ff.fl);
         s4_in.col.green = sat_adj(s3_ff.col.green, s3_ff.sat, s3_ff.fl);
         s4_in.col.blue  = sat_adj(s3_ff.col.blue,  s3_ff.sat, s3_ff.fl);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_ff <= s1_in;
      if (stage_en[1]) s2_ff <= s2_in;
      if (stage_en[2]) s3_ff <= s3_in;
      if (stage_en[3]) s4_ff <= s4_in;
   end

   // Value dimming; full value leaves the colour untouched.
   always_comb begin
      if (s4_ff.val == CHAN_MAX) begin
         rgb = s4_ff.col;
      end else begin
         rgb.red   = dim(s4_ff.col.red,   s4_ff.v2);
         rgb.green = dim(s4_ff.col.green, s4_ff.v2);
         rgb.blue  = dim(s4_ff.col.blue,  s4_ff.v2);
      end
   end

endmodule

// ===== tb/sv/hsv2rgb_checker.sv =====
`timescale 1ns / 100ps
// Checker for the HSV to RGB converter: follows the algorithm register writes and the
// req_ and rsp_ streams, predicts each output color and compares it field by field.
// Depends on hsv2rgb_pkg for the color type and the algorithm codes.
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          failures,
   output int          colors_pending
);

   localparam logic [7:0] HUE_REGION  = 8'd43;
   localparam logic [7:0] THIRD_STEP  = 8'd85;
   localparam logic [7:0] TWO_THIRDS_STEP = 8'd170;
   localparam logic [7:0] GREEN_GAIN  = 8'd185;
   localparam logic [7:0] FULL_LEVEL  = 8'd255;
   localparam int         PRINT_LIMIT = 40;

   // Same layout as req_tdata: hue in the lowest byte.
   typedef struct packed {
      logic [7:0] value;
      logic [7:0] saturation;
      logic [7:0] hue;
   } hsv_type;

   typedef struct {
      hsv_type source;
      logic    algorithm;
      rgb_type color;
   } color_entry_type;

   color_entry_type expected_colors[$];
   color_entry_type entry;
   rgb_type         seen;
   logic            algorithm_sel;

   function automatic logic [7:0] mul_hi8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] full;
      full = a * b;
      return full[15:8];
   endfunction

   function automatic rgb_type six_region_color(input hsv_type c);
      logic [7:0] region;
      logic [7:0] rem;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
      rgb_type    o;
      if (c.saturation == 8'd0) begin
         o = '{c.value, c.value, c.value};
         return o;
      end
      region = c.hue / HUE_REGION;
      rem = 8'((c.hue - region * HUE_REGION) * 6);
      p = mul_hi8(c.value, FULL_LEVEL - c.saturation);
      q = mul_hi8(c.value, FULL_LEVEL - mul_hi8(c.saturation, rem));
      t = mul_hi8(c.value, FULL_LEVEL - mul_hi8(c.saturation, FULL_LEVEL - rem));
      case (region)
         8'd0: o = '{c.value, t, p};
         8'd1: o = '{q, c.value, p};
         8'd2: o = '{p, c.value, t};
         8'd3: o = '{p, q, c.value};
         8'd4: o = '{t, p, c.value};
         default: o = '{c.value, p, q};
      endcase
      return o;
   endfunction

   function automatic rgb_type rainbow_color(input hsv_type c);
      logic [7:0] frac;
      logic [7:0] th;
      logic [7:0] tt;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] floor_level;
      logic [7:0] dim;
      logic [7:0] ch [3];
      frac = {c.hue[4:0], 3'b000};
      th = mul_hi8(frac, THIRD_STEP);
      tt = mul_hi8(frac, TWO_THIRDS_STEP);
      // Eight equal sections of the hue circle, yellow lifted to 171 red.
      case (c.hue[7:5])
         3'd0: begin r = FULL_LEVEL - th; g = th; b = 8'd0; end
         3'd1: begin r = 8'd171; g = 8'd85 + th; b = 8'd0; end
         3'd2: begin r = 8'd171 - tt; g = 8'd170 + th; b = 8'd0; end
         3'd3: begin r = 8'd0; g = FULL_LEVEL - th; b = th; end
         3'd4: begin r = 8'd0; g = 8'd171 - tt; b = 8'd85 + tt; end
         3'd5: begin r = th; g = 8'd0; b = FULL_LEVEL - th; end
         3'd6: begin r = 8'd85 + th; g = 8'd0; b = 8'd171 - th; end
         default: begin r = 8'd170 + th; g = 8'd0; b = 8'd85 - th; end
      endcase
      ch[0] = r;
      ch[1] = mul_hi8(g, GREEN_GAIN);
      ch[2] = b;
      if (c.saturation != FULL_LEVEL) begin
         if (c.saturation == 8'd0) begin
            for (int i = 0; i < 3; i++) ch[i] = FULL_LEVEL;
         end else begin
            // Lit channels are scaled down, then everything is lifted by the white floor.
            floor_level = mul_hi8(FULL_LEVEL - c.saturation, FULL_LEVEL - c.saturation);
            for (int i = 0; i < 3; i++) begin
               if (ch[i] != 8'd0) ch[i] = mul_hi8(ch[i], c.saturation) + 8'd1;
               ch[i] = ch[i] + floor_level;
            end
         end
      end
      if (c.value != FULL_LEVEL) begin
         dim = mul_hi8(c.value, c.value);
         for (int i = 0; i < 3; i++) begin
            if (dim == 8'd0) ch[i] = 8'd0;
            else if (ch[i] != 8'd0) ch[i] = mul_hi8(ch[i], dim) + 8'd1;
         end
      end
      return '{ch[0], ch[1], ch[2]};
   endfunction

   task automatic report_mismatch(input string msg);
      if (failures < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
      failures++;
   endtask

   task automatic check_channel(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0d, want %0d for h=%0d s=%0d v=%0d algo=%0d",
            name, got, want, entry.source.hue, entry.source.saturation,
            entry.source.value, entry.algorithm));
   endtask

   initial begin
      failures = 0;
      colors_pending = 0;
      algorithm_sel = ALGO_GENERIC;
   end

   always @(posedge clock) begin
      if (reset) begin
         algorithm_sel = ALGO_GENERIC;
      end else begin
         if (req_tvalid && req_tready) begin
            entry.source = hsv_type'(req_tdata);
            entry.algorithm = algorithm_sel;
            if (algorithm_sel == ALGO_RAINBOW) entry.color = rainbow_color(entry.source);
            else entry.color = six_region_color(entry.source);
            expected_colors.push_back(entry);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch($sformatf("output word %06h with no input pending",
                                         rsp_tdata));
            end else begin
               entry = expected_colors.pop_front();
               seen = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]};
               check_channel("red", seen.red, entry.color.red);
               check_channel("green", seen.green, entry.color.green);
               check_channel("blue", seen.blue, entry.color.blue);
            end
         end
         // The write takes effect for words accepted after this edge.
         if (csr_wr_en) algorithm_sel = csr_wr_data;
      end
      colors_pending = expected_colors.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the HSV to RGB converter testbench: clock, reset, stimulus and verdict.
// Depends on hsv2rgb_pkg, hsv_to_rgb_converter and hsv2rgb_checker.
module tb
   import hsv2rgb_pkg::*;
();

   localparam int PHASES     = 6;
   localparam int PHASE_WORDS = 315;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // hue [7:0], saturation [15:8], value [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // red [7:0], green [15:8], blue [23:16]
   logic        csr_wr_en;
   logic        csr_wr_data;
   int          failures;
   int          colors_pending;
   bit          calm;

   hsv_to_rgb_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hsv2rgb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .failures       (failures),
      .colors_pending (colors_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Far beyond the slowest correct run with the longest gaps on both sides.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] random_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return 8'd0;
      if (roll < 24) return 8'd255;
      if (roll < 34) return 8'($urandom_range(1, 20));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] val);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {val, sat, hue};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // The register may change only with the pipeline empty.
   task automatic set_algorithm(input logic algo);
      req_tvalid = 1'b0;
      while (colors_pending != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = algo;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            stall = idle_cycles();
         end
      end
   end

   initial begin
      logic [7:0] hue;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      calm = 1'b0;
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Six-region conversion straight out of reset: grey, region edges, last region.
      send_word(8'd0, 8'd0, 8'd0);
      send_word(8'd0, 8'd0, 8'd255);
      send_word(8'd100, 8'd0, 8'd128);
      send_word(8'd0, 8'd255, 8'd255);
      send_word(8'd42, 8'd255, 8'd255);
      send_word(8'd43, 8'd200, 8'd200);
      send_word(8'd128, 8'd255, 8'd255);
      send_word(8'd214, 8'd255, 8'd255);
      send_word(8'd215, 8'd255, 8'd255);
      send_word(8'd255, 8'd1, 8'd1);

      // Rainbow: every section, white at zero saturation, the floor, and dimming to black.
      set_algorithm(ALGO_RAINBOW);
      for (int k = 0; k < 8; k++) send_word(8'(k * 32), 8'd255, 8'd255);
      send_word(8'd31, 8'd255, 8'd255);
      send_word(8'd10, 8'd0, 8'd255);
      send_word(8'd200, 8'd128, 8'd255);
      send_word(8'd100, 8'd1, 8'd255);
      send_word(8'd50, 8'd255, 8'd15);
      send_word(8'd77, 8'd100, 8'd16);
      send_word(8'd255, 8'd0, 8'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         set_algorithm(phase % 2 == 0 ? ALGO_GENERIC : ALGO_RAINBOW);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Regular stretches with no idling on either side.
            calm = (n % 150) < 30;
            if ($urandom_range(0, 3) == 0) hue = random_level();
            else hue = 8'($urandom_range(0, 255));
            send_word(hue, random_level(), random_level());
         end
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      while (colors_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
